/* rtl/core/sclp_pkg.sv */
// Package for the serial command line parser.
// Holds character codes, reply codes, register indexes, reset values and the
// command/status structs shared by the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sclp_pkg;

    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int LINE_BYTES_DEF = 64;

    // Magnitude of a period argument saturates at this value.
    localparam int MAG_W = 21;
    localparam logic [MAG_W-1:0] MAG_CAP = 21'h100000;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST = 16'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST = 16'd5000;

    localparam logic [KIND_W-1:0] KIND_OK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BADARG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX = 1'd1;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [2:0] WORD_LEN = 3'd6;

    typedef struct packed {
        logic store;   // append a plain byte to the line
        logic start;   // line end accepted, begin the scan
        logic scan;    // scan in progress
        logic finish;  // load the reply register and empty the line
    } sclp_cmd_t;

    typedef struct packed {
        logic eol;        // the offered byte is CR or LF
        logic scan_done;  // every stored byte up to the end or a zero byte has been parsed
        logic out_free;   // the reply register can take a new transaction
    } sclp_stat_t;

    function automatic logic [BYTE_W-1:0] status_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            3'd0:    c = "s";
            3'd1:    c = "t";
            3'd2:    c = "a";
            3'd3:    c = "t";
            3'd4:    c = "u";
            3'd5:    c = "s";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] period_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            3'd0:    c = "p";
            3'd1:    c = "e";
            3'd2:    c = "r";
            3'd3:    c = "i";
            3'd4:    c = "o";
            3'd5:    c = "d";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR) || (c == CH_SP);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sclp_if.sv */
// Channel interfaces of the serial command line parser.
// Byte input, reply output and register write channels; widths come from sclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sclp_rx_if;
    logic                            valid;
    logic                            ready;
    logic [sclp_pkg::BYTE_W-1:0]     rx_byte;
    logic                            led_blink;
    logic [sclp_pkg::PERIOD_W-1:0]   led_period;

    modport source (output valid, output rx_byte, output led_blink, output led_period,
                    input ready);
    modport sink   (input valid, input rx_byte, input led_blink, input led_period,
                    output ready);
endinterface

interface sclp_reply_if;
    logic                            valid;
    logic                            ready;
    logic [sclp_pkg::KIND_W-1:0]     reply_kind;
    logic                            mode_blink;
    logic [sclp_pkg::PERIOD_W-1:0]   period_value;
    logic                            period_write;

    modport source (output valid, output reply_kind, output mode_blink,
                    output period_value, output period_write, input ready);
    modport sink   (input valid, input reply_kind, input mode_blink,
                    input period_value, input period_write, output ready);
endinterface

interface sclp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sclp_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [sclp_pkg::PERIOD_W-1:0]   wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/sclp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/sclp_ctrl.sv */
// Controller of the serial command line parser: collect, scan and reply sequencing.
// Depends on sclp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sclp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sclp_pkg::sclp_stat_t st,
    output sclp_pkg::sclp_cmd_t       cmd
);
    import sclp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.store  = (state_reg == S_IDLE) && in_valid && !st.eol;
        cmd.start  = (state_reg == S_IDLE) && in_valid && st.eol;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.finish = (state_reg == S_FINISH) && st.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && st.eol)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sclp_dpath.sv */
// Datapath of the serial command line parser: line store, byte-serial tokenizer,
// argument decoder, limit registers and reply register. Depends on sclp_pkg, sclp_ram.
`timescale 1ns / 1ps
`default_nettype none

module sclp_dpath #(
    parameter int LINE_BYTES = sclp_pkg::LINE_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [sclp_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                            led_blink,
    input  wire logic [sclp_pkg::PERIOD_W-1:0]   led_period,
    input  wire logic                            cfg_we,
    input  wire logic [sclp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sclp_pkg::PERIOD_W-1:0]   cfg_data,
    input  wire sclp_pkg::sclp_cmd_t             cmd,
    output sclp_pkg::sclp_stat_t                 st,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [sclp_pkg::KIND_W-1:0]          reply_kind,
    output logic                                 mode_blink,
    output logic [sclp_pkg::PERIOD_W-1:0]        period_value,
    output logic                                 period_write
);
    import sclp_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] LEN_MAX = AW'(LINE_BYTES - 1);
    localparam int ACC_W = MAG_W + 3;

    typedef enum logic [2:0] {
        P_LEAD,   // skipping spaces before the command
        P_CMD,    // inside the command token
        P_GAP,    // skipping spaces before the argument
        P_ARG,    // inside the argument token
        P_DONE    // remaining tokens are ignored
    } phase_t;

    typedef enum logic [1:0] {
        A_BLANK,
        A_SIGN,
        A_DIG,
        A_BAD
    } arg_t;

    typedef enum logic [1:0] {
        CMD_UNKNOWN,
        CMD_STATUS,
        CMD_PERIOD
    } cmd_kind_t;

    // Line store and scan pointers.
    logic [AW-1:0]       len_reg;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic                stop_reg, stop_next;
    logic [BYTE_W-1:0]   rd_data;
    logic                ram_we;

    // Tokenizer state.
    phase_t              ph_reg, ph_next;
    cmd_kind_t           kind_reg, kind_next;
    logic [2:0]          clen_reg, clen_next;
    logic                st_m_reg, st_m_next;
    logic                pd_m_reg, pd_m_next;
    arg_t                arg_reg, arg_next;
    logic                neg_reg, neg_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;

    logic                blink_reg;
    logic [PERIOD_W-1:0] cur_period_reg;
    logic [PERIOD_W-1:0] pmin_reg;
    logic [PERIOD_W-1:0] pmax_reg;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_out_reg;
    logic                blink_out_reg;
    logic [PERIOD_W-1:0] period_out_reg;
    logic                write_out_reg;

    // Byte step helpers.
    logic                consume;
    logic [BYTE_W-1:0]   c;
    logic [2:0]          cs_len;
    logic                cs_st, cs_pd;
    logic                tok_status, tok_period;
    logic                is_digit;
    logic [ACC_W-1:0]    acc;
    logic [MAG_W-1:0]    acc_sat;
    arg_t                as_arg;
    logic                as_neg;
    logic [MAG_W-1:0]    as_mag;
    logic                arg_ok;

    logic [KIND_W-1:0]   fin_kind;
    logic                fin_blink;
    logic [PERIOD_W-1:0] fin_period;
    logic                fin_write;

    assign ram_we = cmd.store && (len_reg < LEN_MAX);

    sclp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg),
        .wdata (rx_byte),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    assign st.eol       = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign st.scan_done = !pend_reg && (stop_reg || (rd_idx_reg == len_reg));
    assign st.out_free  = !out_valid_reg || out_ready;

    assign consume = cmd.scan && pend_reg && !stop_reg;
    assign c       = rd_data;

    // One character of the command token.
    always_comb
    begin
        cs_len = (clen_reg == 3'd7) ? clen_reg : clen_reg + 3'd1;
        if (clen_reg < WORD_LEN)
        begin
            cs_st = st_m_reg && (c == status_char(clen_reg));
            cs_pd = pd_m_reg && (c == period_char(clen_reg));
        end
        else
        begin
            cs_st = 1'b0;
            cs_pd = 1'b0;
        end
    end

    assign tok_status = (clen_reg == WORD_LEN) && st_m_reg;
    assign tok_period = (clen_reg == WORD_LEN) && pd_m_reg;

    // One character of the argument token; the magnitude saturates.
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
               + ACC_W'(c - CH_ZERO);
    assign acc_sat = (acc > ACC_W'(MAG_CAP)) ? MAG_CAP : acc[MAG_W-1:0];

    always_comb
    begin
        as_arg = arg_reg;
        as_neg = neg_reg;
        as_mag = mag_reg;
        unique case (arg_reg)
            A_BLANK:
            begin
                if (is_blank(c))
                begin
                    as_arg = A_BLANK;
                end
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    as_neg = (c == CH_MINUS);
                    as_arg = A_SIGN;
                end
                else if (is_digit)
                begin
                    as_mag = acc_sat;
                    as_arg = A_DIG;
                end
                else
                begin
                    as_arg = A_BAD;
                end
            end
            A_SIGN, A_DIG:
            begin
                if (is_digit)
                begin
                    as_mag = acc_sat;
                    as_arg = A_DIG;
                end
                else
                begin
                    as_arg = A_BAD;
                end
            end
            A_BAD:   as_arg = A_BAD;
            default: as_arg = A_BAD;
        endcase
    end

    // Scan sequencing and tokenizer.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        pend_next   = 1'b0;
        stop_next   = stop_reg;
        ph_next     = ph_reg;
        kind_next   = kind_reg;
        clen_next   = clen_reg;
        st_m_next   = st_m_reg;
        pd_m_next   = pd_m_reg;
        arg_next    = arg_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;

        if (cmd.start)
        begin
            rd_idx_next = '0;
            stop_next   = 1'b0;
            ph_next     = P_LEAD;
            kind_next   = CMD_UNKNOWN;
            clen_next   = 3'd0;
            st_m_next   = 1'b1;
            pd_m_next   = 1'b1;
            arg_next    = A_BLANK;
            neg_next    = 1'b0;
            mag_next    = '0;
        end
        else if (cmd.scan)
        begin
            if (!stop_reg && (rd_idx_reg < len_reg))
            begin
                rd_idx_next = rd_idx_reg + AW'(1);
                pend_next   = 1'b1;
            end
            if (consume)
            begin
                if (c == CH_NUL)
                begin
                    // A zero byte ends the line early.
                    stop_next = 1'b1;
                end
                else
                begin
                    unique case (ph_reg)
                        P_LEAD:
                        begin
                            if (c != CH_SP)
                            begin
                                ph_next   = P_CMD;
                                clen_next = cs_len;
                                st_m_next = cs_st;
                                pd_m_next = cs_pd;
                            end
                        end
                        P_CMD:
                        begin
                            if (c == CH_SP)
                            begin
                                if (tok_status)
                                begin
                                    kind_next = CMD_STATUS;
                                    ph_next   = P_DONE;
                                end
                                else if (tok_period)
                                begin
                                    kind_next = CMD_PERIOD;
                                    ph_next   = P_GAP;
                                end
                                else
                                begin
                                    kind_next = CMD_UNKNOWN;
                                    ph_next   = P_DONE;
                                end
                            end
                            else
                            begin
                                clen_next = cs_len;
                                st_m_next = cs_st;
                                pd_m_next = cs_pd;
                            end
                        end
                        P_GAP:
                        begin
                            if (c != CH_SP)
                            begin
                                ph_next  = P_ARG;
                                arg_next = as_arg;
                                neg_next = as_neg;
                                mag_next = as_mag;
                            end
                        end
                        P_ARG:
                        begin
                            if (c == CH_SP)
                            begin
                                ph_next = P_DONE;
                            end
                            else
                            begin
                                arg_next = as_arg;
                                neg_next = as_neg;
                                mag_next = as_mag;
                            end
                        end
                        P_DONE:  ph_next = P_DONE;
                        default: ph_next = P_DONE;
                    endcase
                end
            end
        end
    end

    assign arg_ok = (arg_reg == A_DIG) && !(neg_reg && (mag_reg != '0)) &&
                    (mag_reg >= MAG_W'(pmin_reg)) && (mag_reg <= MAG_W'(pmax_reg));

    // Reply decode at the end of the scan.
    always_comb
    begin
        fin_kind   = KIND_UNKNOWN;
        fin_blink  = 1'b0;
        fin_period = '0;
        fin_write  = 1'b0;
        unique case (ph_reg)
            P_LEAD:
            begin
                fin_kind = KIND_UNKNOWN;
            end
            P_CMD:
            begin
                if (tok_status)
                begin
                    fin_kind   = KIND_OK;
                    fin_blink  = blink_reg;
                    fin_period = cur_period_reg;
                end
                else if (tok_period)
                begin
                    fin_kind = KIND_BADARG;
                end
            end
            P_GAP:
            begin
                fin_kind = KIND_BADARG;
            end
            P_ARG, P_DONE:
            begin
                if ((ph_reg == P_DONE) && (kind_reg == CMD_STATUS))
                begin
                    fin_kind   = KIND_OK;
                    fin_blink  = blink_reg;
                    fin_period = cur_period_reg;
                end
                else if ((ph_reg == P_DONE) && (kind_reg == CMD_UNKNOWN))
                begin
                    fin_kind = KIND_UNKNOWN;
                end
                else if (arg_ok)
                begin
                    fin_kind   = KIND_OK;
                    fin_blink  = blink_reg;
                    fin_period = mag_reg[PERIOD_W-1:0];
                    fin_write  = 1'b1;
                end
                else
                begin
                    fin_kind = KIND_BADARG;
                end
            end
            default: fin_kind = KIND_UNKNOWN;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            ph_reg        <= P_LEAD;
            kind_reg      <= CMD_UNKNOWN;
            clen_reg      <= 3'd0;
            st_m_reg      <= 1'b1;
            pd_m_reg      <= 1'b1;
            arg_reg       <= A_BLANK;
            neg_reg       <= 1'b0;
            pmin_reg      <= PERIOD_MIN_RST;
            pmax_reg      <= PERIOD_MAX_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                len_reg <= '0;
            end
            else if (ram_we)
            begin
                len_reg <= len_reg + AW'(1);
            end
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            stop_reg   <= stop_next;
            ph_reg     <= ph_next;
            kind_reg   <= kind_next;
            clen_reg   <= clen_next;
            st_m_reg   <= st_m_next;
            pd_m_reg   <= pd_m_next;
            arg_reg    <= arg_next;
            neg_reg    <= neg_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PERIOD_MIN: pmin_reg <= cfg_data;
                    CFG_PERIOD_MAX: pmax_reg <= cfg_data;
                    default:        pmin_reg <= pmin_reg;
                endcase
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (cmd.start)
        begin
            blink_reg      <= led_blink;
            cur_period_reg <= led_period;
        end
        if (cmd.finish)
        begin
            kind_out_reg   <= fin_kind;
            blink_out_reg  <= fin_blink;
            period_out_reg <= fin_period;
            write_out_reg  <= fin_write;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reply_kind   = kind_out_reg;
    assign mode_blink   = blink_out_reg;
    assign period_value = period_out_reg;
    assign period_write = write_out_reg;

endmodule

`default_nettype wire

/* rtl/core/serial_command_line_parser.sv */
// Channel    Dir  Handshake     Payload
// rx         in   valid/ready   rx_byte, led_blink, led_period
// reply      out  valid/ready   reply_kind, mode_blink, period_value, period_write
// cfg        in   valid/ready   reg_index, wr_data (ready is always high)
//
// A plain byte is taken whenever rx is ready. A CR or LF closes rx while the stored
// line is scanned (the scan ends early after a zero byte) and the reply is loaded:
// the line memory is read one byte per cycle through its read port.
// The reply register holds a result until it is taken; a line end that arrives
// while it is still full waits in the final step. Reset empties the line and
// restores the period limits to 50 and 5000; the line memory itself is not cleared.
// Top level of the serial command line parser. Depends on sclp_pkg, sclp_if,
// sclp_ram, sclp_ctrl and sclp_dpath.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_parser #(
    parameter int LINE_BYTES = sclp_pkg::LINE_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sclp_rx_if.sink     rx,
    sclp_reply_if.source reply,
    sclp_cfg_if.sink    cfg
);
    import sclp_pkg::*;

    sclp_cmd_t  cmd;
    sclp_stat_t st;

    assign cfg.ready = 1'b1;

    sclp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .st       (st),
        .cmd      (cmd)
    );

    sclp_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx.rx_byte),
        .led_blink    (rx.led_blink),
        .led_period   (rx.led_period),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.reg_index),
        .cfg_data     (cfg.wr_data),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (reply.valid),
        .out_ready    (reply.ready),
        .reply_kind   (reply.reply_kind),
        .mode_blink   (reply.mode_blink),
        .period_value (reply.period_value),
        .period_write (reply.period_write)
    );

    // A period write strobe only ever goes with an OK reply.
    a_write_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid && reply.period_write |-> reply.reply_kind == KIND_OK)
        else $error("period write strobe on an error reply");

    // Error replies carry no mode and no period.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid && (reply.reply_kind != KIND_OK) |->
            (reply.mode_blink == 1'b0) && (reply.period_value == '0))
        else $error("error reply with nonzero mode or period");

    // A line end starts a scan, so the byte channel closes in the next cycle.
    a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready && ((rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF))
            |=> !rx.ready)
        else $error("byte channel open right after a line end");

    // Every reply on offer carries one of the three defined kinds.
    a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |-> (reply.reply_kind == KIND_OK) ||
            (reply.reply_kind == KIND_BADARG) || (reply.reply_kind == KIND_UNKNOWN))
        else $error("reply kind outside the defined codes");

endmodule

`default_nettype wire
